>>> design/sensor_reply_frame_checker_defines.svh
// ----------------------------------------------------------------------------
// sensor_reply_frame_checker_defines.svh
// Assertion macros used by the reply checker's assertion module.
// ----------------------------------------------------------------------------
`ifndef SENSOR_REPLY_FRAME_CHECKER_DEFINES_SVH
`define SENSOR_REPLY_FRAME_CHECKER_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while in reset
`define SRFC_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("srfc assertion failed");

// Next-cycle implication, sampled on clk, off while in reset
`define SRFC_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("srfc assertion failed");

`endif

>>> design/srfc_pkg.sv
// ----------------------------------------------------------------------------
// srfc_pkg
// Types, constants and the CRC-8 step for the sensor reply frame checker.
// ----------------------------------------------------------------------------
package srfc_pkg;

	// Reply status codes, ranked: lower nonzero code wins
	typedef enum logic [2:0] {
		ST_OK      = 3'd0,
		ST_HEADER  = 3'd1,
		ST_MARKER  = 3'd2,
		ST_LENGTH  = 3'd3,
		ST_SUM     = 3'd4,
		ST_COMMAND = 3'd5
	} status_t;

	// Configuration register indexes
	localparam logic [1:0] REG_INTERFACE_MODE = 2'd0;
	localparam logic [1:0] REG_REPLY_KIND     = 2'd1;

	// Last byte position of each reply form
	localparam logic [4:0] TW_LAST       = 5'd29;
	localparam logic [4:0] SER_FULL_LAST = 5'd10;
	localparam logic [4:0] SER_PM25_LAST = 5'd6;

	// Serial framing bytes
	localparam logic [7:0] SER_HEADER  = 8'hFE;
	localparam logic [7:0] SER_MARKER  = 8'hA5;
	localparam logic [7:0] SER_LENGTH  = 8'h02;
	localparam logic [7:0] SER_COMMAND = 8'h00;

	// CRC-8 parameters
	localparam logic [7:0] CRC_POLY = 8'h31;
	localparam logic [7:0] CRC_INIT = 8'hFF;

	typedef struct packed {
		logic serial;     // 1: serial framed reply
		logic pm25_only;  // serial only: short PM2.5 reply
	} cfg_t;

	typedef struct packed {
		status_t     status;
		logic [15:0] pm1p0;
		logic [15:0] pm2p5;
		logic [15:0] pm10;
	} result_t;

	// One byte through the MSB-first CRC-8, no reflection
	function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
		logic [7:0] c;
		c = crc ^ b;
		for (int k = 0; k < 8; k++) begin
			c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
		end
		return c;
	endfunction

endpackage

>>> design/srfc_frame.sv
// ----------------------------------------------------------------------------
// srfc_frame
// Per-byte reply state: position, CRC and sum accumulators, first error and
// readings. Evaluates one registered byte per cycle while step is high and
// forms the result on the last byte of a reply.
// ----------------------------------------------------------------------------
module srfc_frame (
	input  logic             clk,
	input  logic             arst_n,
	input  srfc_pkg::cfg_t   cfg,
	input  logic             step,
	input  logic [7:0]       rx_byte,
	input  logic             frame_start,
	output logic             last_byte,
	output srfc_pkg::result_t result
);
	import srfc_pkg::*;

	logic [4:0]  idx_q;
	logic [7:0]  crc_q;
	logic [7:0]  sum_q;
	status_t     err_q;
	logic [15:0] pm1p0_q, pm2p5_q, pm10_q;

	logic [4:0]  last_c, idx_c;
	logic        clr_c;
	logic [7:0]  crc_c, sum_c, crc_n, sum_n;
	status_t     err_c, err_n, code_c;
	logic [15:0] pm1p0_c, pm2p5_c, pm10_c;
	logic [15:0] pm1p0_n, pm2p5_n, pm10_n;

	// Reply length and restart of a partial reply
	assign last_c = !cfg.serial ? TW_LAST : (cfg.pm25_only ? SER_PM25_LAST : SER_FULL_LAST);
	assign clr_c  = frame_start || (idx_q > last_c);

	assign idx_c   = clr_c ? 5'd0 : idx_q;
	assign crc_c   = clr_c ? CRC_INIT : crc_q;
	assign sum_c   = clr_c ? 8'd0 : sum_q;
	assign err_c   = clr_c ? ST_OK : err_q;
	assign pm1p0_c = clr_c ? 16'd0 : pm1p0_q;
	assign pm2p5_c = clr_c ? 16'd0 : pm2p5_q;
	assign pm10_c  = clr_c ? 16'd0 : pm10_q;

	assign last_byte = (idx_c == last_c);

	// Checks, accumulators and readings for this byte
	always_comb begin
		crc_n   = crc_c;
		sum_n   = sum_c;
		code_c  = ST_OK;
		pm1p0_n = pm1p0_c;
		pm2p5_n = pm2p5_c;
		pm10_n  = pm10_c;
		if (!cfg.serial) begin
			// two-wire: words at 0-1, 3-4, 9-10, CRC in the byte after each
			unique case (idx_c)
				5'd0, 5'd3, 5'd9:   crc_n = crc8_step(CRC_INIT, rx_byte);
				5'd1, 5'd4, 5'd10:  crc_n = crc8_step(crc_c, rx_byte);
				5'd2, 5'd5, 5'd11: begin
					if (crc_c != rx_byte) code_c = ST_SUM;
					crc_n = CRC_INIT;
				end
				default: ;
			endcase
			unique case (idx_c)
				5'd0:    pm1p0_n[15:8] = rx_byte;
				5'd1:    pm1p0_n[7:0]  = rx_byte;
				5'd3:    pm2p5_n[15:8] = rx_byte;
				5'd4:    pm2p5_n[7:0]  = rx_byte;
				5'd9:    pm10_n[15:8]  = rx_byte;
				5'd10:   pm10_n[7:0]   = rx_byte;
				default: ;
			endcase
		end else begin
			// serial: framing bytes, running sum, sum byte last
			unique case (idx_c)
				5'd0:    if (rx_byte != SER_HEADER)  code_c = ST_HEADER;
				5'd1:    if (rx_byte != SER_MARKER)  code_c = ST_MARKER;
				5'd2:    if (rx_byte != SER_LENGTH)  code_c = ST_LENGTH;
				5'd3:    if (rx_byte != SER_COMMAND) code_c = ST_COMMAND;
				default: if (last_byte && (sum_c != rx_byte)) code_c = ST_SUM;
			endcase
			if ((idx_c != 5'd0) && (idx_c < last_c)) sum_n = sum_c + rx_byte;
			if (cfg.pm25_only) begin
				unique case (idx_c)
					5'd4:    pm2p5_n[15:8] = rx_byte;
					5'd5:    pm2p5_n[7:0]  = rx_byte;
					default: ;
				endcase
			end else begin
				unique case (idx_c)
					5'd4:    pm1p0_n[15:8] = rx_byte;
					5'd5:    pm1p0_n[7:0]  = rx_byte;
					5'd6:    pm2p5_n[15:8] = rx_byte;
					5'd7:    pm2p5_n[7:0]  = rx_byte;
					5'd8:    pm10_n[15:8]  = rx_byte;
					5'd9:    pm10_n[7:0]   = rx_byte;
					default: ;
				endcase
			end
		end
		// keep the highest-ranked failure
		err_n = ((code_c != ST_OK) && ((err_c == ST_OK) || (code_c < err_c))) ? code_c : err_c;
	end

	// Result of a finished reply; readings forced to zero on error, PM1.0 and PM10 zero in PM2.5-only mode
	always_comb begin
		result.status = err_n;
		if (err_n != ST_OK) begin
			result.pm1p0 = 16'd0;
			result.pm2p5 = 16'd0;
			result.pm10  = 16'd0;
		end else begin
			result.pm1p0 = cfg.pm25_only ? 16'd0 : pm1p0_n;
			result.pm2p5 = pm2p5_n;
			result.pm10  = cfg.pm25_only ? 16'd0 : pm10_n;
		end
	end

	// Reply state; cleared after the last byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q   <= 5'd0;
			crc_q   <= CRC_INIT;
			sum_q   <= 8'd0;
			err_q   <= ST_OK;
			pm1p0_q <= 16'd0;
			pm2p5_q <= 16'd0;
			pm10_q  <= 16'd0;
		end else if (step) begin
			if (last_byte) begin
				idx_q   <= 5'd0;
				crc_q   <= CRC_INIT;
				sum_q   <= 8'd0;
				err_q   <= ST_OK;
				pm1p0_q <= 16'd0;
				pm2p5_q <= 16'd0;
				pm10_q  <= 16'd0;
			end else begin
				idx_q   <= idx_c + 5'd1;
				crc_q   <= crc_n;
				sum_q   <= sum_n;
				err_q   <= err_n;
				pm1p0_q <= pm1p0_n;
				pm2p5_q <= pm2p5_n;
				pm10_q  <= pm10_n;
			end
		end
	end

endmodule

>>> design/sensor_reply_frame_checker.sv
// A result is loaded into the result register when a reply's last byte leaves the input register.
// Throughput: one byte per cycle unless a held result stalls input; each byte is evaluated in one pass between
// the input register and the result register.
// A held result stalls input only when the byte waiting is a reply's last.
// Reset (arst_n low, asynchronous): registers to two-wire full reply, reply
// state cleared, no result pending.
// ----------------------------------------------------------------------------
// sensor_reply_frame_checker
// Top level: input register, configuration registers, reply evaluation and
// result register with valid/ready handshakes.
// ----------------------------------------------------------------------------
module sensor_reply_frame_checker (
	input  logic        clk,
	input  logic        arst_n,
	// configuration write port
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic        cfg_data,
	// byte input
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  rx_byte,
	input  logic        frame_start,
	// result output
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  status,
	output logic [15:0] pm1p0,
	output logic [15:0] pm2p5,
	output logic [15:0] pm10
);
	import srfc_pkg::*;

	logic       mode_q, kind_q;
	cfg_t       cfg;
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       start_s1;
	logic       last_byte, advance;
	result_t    result;
	logic       out_valid_q;
	result_t    result_q;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= 1'b0;
			kind_q <= 1'b0;
		end else if (cfg_we) begin
			if (cfg_index == REG_INTERFACE_MODE) mode_q <= cfg_data;
			if (cfg_index == REG_REPLY_KIND)     kind_q <= cfg_data;
		end
	end

	assign cfg.serial    = mode_q;
	assign cfg.pm25_only = mode_q & kind_q;

	// Byte leaves stage 1 unless it finishes a reply and the result is still held
	assign advance  = valid_s1 && (!last_byte || !out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1  <= rx_byte;
			start_s1 <= frame_start;
		end
	end

	srfc_frame u_frame (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.step       (advance),
		.rx_byte    (byte_s1),
		.frame_start(start_s1),
		.last_byte  (last_byte),
		.result     (result)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && last_byte) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && last_byte) result_q <= result;
	end

	assign out_valid = out_valid_q;
	assign status    = result_q.status;
	assign pm1p0     = result_q.pm1p0;
	assign pm2p5     = result_q.pm2p5;
	assign pm10      = result_q.pm10;

endmodule

>>> design/srfc_checker.sv
// ----------------------------------------------------------------------------
// srfc_checker
// Port-level assertions for the sensor reply frame checker, bound to the top.
// ----------------------------------------------------------------------------
`include "sensor_reply_frame_checker_defines.svh"

module srfc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [2:0]  status,
	input logic [15:0] pm1p0,
	input logic [15:0] pm2p5,
	input logic [15:0] pm10
);
	import srfc_pkg::*;

	// held result keeps its transaction until taken
	`SRFC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
		out_valid && $stable(status) && $stable(pm1p0) && $stable(pm2p5) && $stable(pm10))

	// a valid result's status is always a defined code
	`SRFC_ASSERT_NOW(a_status_code, out_valid, status <= ST_COMMAND)

	// a failed reply reports no readings
	`SRFC_ASSERT_NOW(a_err_zero, out_valid && (status != ST_OK),
		(pm1p0 == 16'd0) && (pm2p5 == 16'd0) && (pm10 == 16'd0))

	// with no result pending, input is never stalled
	`SRFC_ASSERT_NOW(a_no_stall, !out_valid, in_ready)

endmodule

bind sensor_reply_frame_checker srfc_checker u_srfc_checker (.*);

>>> test/tb_sensor_reply_frame_checker.sv
// ----------------------------------------------------------------------------
// tb_sensor_reply_frame_checker
// Self-checking bench for the sensor reply checker. Serial and two-wire replies
// are streamed byte by byte under random sender gaps and receiver stalls. The
// replies are mostly well formed, some carry injected framing, sum or CRC
// faults, and the rest are truncated replies and noise. A local reply model
// predicts every status and reading, and each result is compared against it.
// ----------------------------------------------------------------------------
module tb_sensor_reply_frame_checker;
	timeunit 1ns;
	timeprecision 1ps;

	import srfc_pkg::*;

	localparam int RANDOM_BYTES = 1650;
	localparam int CYCLE_LIMIT  = 300000;
	localparam int SETTLE_CYCLES = 4;

	// Unmapped register indexes, writes there must be ignored
	localparam logic [1:0] REG_UNMAPPED_A = 2'd2;
	localparam logic [1:0] REG_UNMAPPED_B = 2'd3;

	// Fault injection bits (serial framing / sum; two-wire uses 0..2 per word CRC)
	localparam int FLT_HEADER  = 0;
	localparam int FLT_MARKER  = 1;
	localparam int FLT_LENGTH  = 2;
	localparam int FLT_COMMAND = 3;
	localparam int FLT_SUM     = 4;

	// Receiver stall styles
	localparam int RDY_ALWAYS  = 0;
	localparam int RDY_PATTERN = 1;
	localparam int RDY_SPARSE  = 2;

	typedef struct packed {
		logic [7:0] value;
		logic       start;
	} reply_byte_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_index = REG_INTERFACE_MODE;
	logic        cfg_data = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [7:0]  rx_byte = 8'h00;
	logic        frame_start = 1'b0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [2:0]  status;
	logic [15:0] pm1p0;
	logic [15:0] pm2p5;
	logic [15:0] pm10;

	sensor_reply_frame_checker u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.rx_byte    (rx_byte),
		.frame_start(frame_start),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.status     (status),
		.pm1p0      (pm1p0),
		.pm2p5      (pm2p5),
		.pm10       (pm10)
	);

	always #1 clk = ~clk;

	// Bench copy of the registers and the reply state
	logic        cfg_serial = 1'b0;
	logic        cfg_pm25_only = 1'b0;
	logic [4:0]  reply_pos;
	logic [7:0]  word_crc;
	logic [7:0]  frame_sum;
	status_t     first_fault;
	logic [15:0] pm1p0_acc;
	logic [15:0] pm2p5_acc;
	logic [15:0] pm10_acc;

	reply_byte_t pending_bytes[$];
	result_t     awaited_replies[$];
	int          queued_count = 0;
	int          accepted_count = 0;
	int          mismatch_count = 0;
	int          cycle_count = 0;
	logic        byte_taken = 1'b0;

	// MSB-first CRC-8, one input bit per iteration
	function automatic logic [7:0] crc8_next(input logic [7:0] crc, input logic [7:0] b);
		logic [7:0] r;
		r = crc;
		for (int i = 7; i >= 0; i--)
			r = {r[6:0], 1'b0} ^ ((r[7] ^ b[i]) ? CRC_POLY : 8'h00);
		return r;
	endfunction

	function automatic logic [7:0] nonzero_byte();
		return 8'($urandom_range(1, 255));
	endfunction

	function automatic logic [15:0] pick_reading();
		case ($urandom_range(0, 9))
			0: return 16'h0000;
			1: return 16'hFFFF;
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic clear_reply_state();
		reply_pos   = 5'd0;
		word_crc    = CRC_INIT;
		frame_sum   = 8'h00;
		first_fault = ST_OK;
		pm1p0_acc   = 16'h0000;
		pm2p5_acc   = 16'h0000;
		pm10_acc    = 16'h0000;
	endtask

	// Lowest nonzero code wins
	task automatic note_fault(input status_t code);
		if (first_fault == ST_OK || code < first_fault)
			first_fault = code;
	endtask

	// Reply model: one accepted byte in, at most one expected result queued
	task automatic advance_reply(input logic [7:0] b, input logic start);
		logic [4:0] last_pos;
		logic       pm25;
		result_t    res;
		pm25 = cfg_serial && cfg_pm25_only;
		last_pos = !cfg_serial ? TW_LAST : (pm25 ? SER_PM25_LAST : SER_FULL_LAST);
		if (start || reply_pos > last_pos)
			clear_reply_state();

		if (!cfg_serial) begin
			// word CRCs: two data bytes then the check byte
			case (reply_pos)
				5'd0, 5'd3, 5'd9: word_crc = crc8_next(CRC_INIT, b);
				5'd1, 5'd4, 5'd10: word_crc = crc8_next(word_crc, b);
				5'd2, 5'd5, 5'd11: begin
					if (word_crc != b)
						note_fault(ST_SUM);
					word_crc = CRC_INIT;
				end
				default: ;
			endcase
			case (reply_pos)
				5'd0: pm1p0_acc[15:8] = b;
				5'd1: pm1p0_acc[7:0] = b;
				5'd3: pm2p5_acc[15:8] = b;
				5'd4: pm2p5_acc[7:0] = b;
				5'd9: pm10_acc[15:8] = b;
				5'd10: pm10_acc[7:0] = b;
				default: ;
			endcase
		end else begin
			// framing checks, ranked by code
			if (reply_pos == 5'd0 && b != SER_HEADER) note_fault(ST_HEADER);
			if (reply_pos == 5'd1 && b != SER_MARKER) note_fault(ST_MARKER);
			if (reply_pos == 5'd2 && b != SER_LENGTH) note_fault(ST_LENGTH);
			if (reply_pos == 5'd3 && b != SER_COMMAND) note_fault(ST_COMMAND);
			if (reply_pos >= 5'd1 && reply_pos < last_pos)
				frame_sum = frame_sum + b;
			if (reply_pos == last_pos && frame_sum != b)
				note_fault(ST_SUM);
			if (pm25) begin
				case (reply_pos)
					5'd4: pm2p5_acc[15:8] = b;
					5'd5: pm2p5_acc[7:0] = b;
					default: ;
				endcase
			end else begin
				case (reply_pos)
					5'd4: pm1p0_acc[15:8] = b;
					5'd5: pm1p0_acc[7:0] = b;
					5'd6: pm2p5_acc[15:8] = b;
					5'd7: pm2p5_acc[7:0] = b;
					5'd8: pm10_acc[15:8] = b;
					5'd9: pm10_acc[7:0] = b;
					default: ;
				endcase
			end
		end

		if (reply_pos == last_pos) begin
			res.status = first_fault;
			res.pm1p0  = (first_fault != ST_OK || pm25) ? 16'h0000 : pm1p0_acc;
			res.pm2p5  = (first_fault != ST_OK) ? 16'h0000 : pm2p5_acc;
			res.pm10   = (first_fault != ST_OK || pm25) ? 16'h0000 : pm10_acc;
			awaited_replies.push_back(res);
			clear_reply_state();
		end else begin
			reply_pos = reply_pos + 5'd1;
		end
	endtask

	task automatic queue_byte(input logic [7:0] value, input logic start);
		reply_byte_t item;
		item.value = value;
		item.start = start;
		pending_bytes.push_back(item);
		queued_count++;
	endtask

	// Builds one reply for the current settings; cut trims it to a prefix
	task automatic queue_reply(input logic [4:0] faults, input logic [15:0] v1,
			input logic [15:0] v2, input logic [15:0] v3, input logic start,
			input int cut);
		logic [7:0] fb [0:29];
		logic [7:0] sum;
		int         n;
		for (int i = 0; i < 30; i++)
			fb[i] = 8'($urandom);
		if (!cfg_serial) begin
			n = 30;
			{fb[0], fb[1]} = v1;
			{fb[3], fb[4]} = v2;
			{fb[9], fb[10]} = v3;
			fb[2] = crc8_next(crc8_next(CRC_INIT, fb[0]), fb[1])
				^ (faults[0] ? nonzero_byte() : 8'h00);
			fb[5] = crc8_next(crc8_next(CRC_INIT, fb[3]), fb[4])
				^ (faults[1] ? nonzero_byte() : 8'h00);
			fb[11] = crc8_next(crc8_next(CRC_INIT, fb[9]), fb[10])
				^ (faults[2] ? nonzero_byte() : 8'h00);
		end else begin
			n = cfg_pm25_only ? 7 : 11;
			fb[0] = SER_HEADER ^ (faults[FLT_HEADER] ? nonzero_byte() : 8'h00);
			fb[1] = SER_MARKER ^ (faults[FLT_MARKER] ? nonzero_byte() : 8'h00);
			fb[2] = SER_LENGTH ^ (faults[FLT_LENGTH] ? nonzero_byte() : 8'h00);
			fb[3] = SER_COMMAND ^ (faults[FLT_COMMAND] ? nonzero_byte() : 8'h00);
			if (cfg_pm25_only) begin
				{fb[4], fb[5]} = v2;
			end else begin
				{fb[4], fb[5]} = v1;
				{fb[6], fb[7]} = v2;
				{fb[8], fb[9]} = v3;
			end
			sum = 8'h00;
			for (int i = 1; i < n - 1; i++)
				sum = sum + fb[i];
			fb[n - 1] = sum ^ (faults[FLT_SUM] ? nonzero_byte() : 8'h00);
		end
		for (int i = 0; i < cut && i < n; i++)
			queue_byte(fb[i], start && i == 0);
	endtask

	// Every byte taken, every result seen, then let the pipeline settle
	task automatic wait_idle();
		while (accepted_count != queued_count || awaited_replies.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// Register writes, only called while the block is idle
	task automatic load_settings(input logic serial, input logic pm25);
		cfg_we    <= 1'b1;
		cfg_index <= REG_INTERFACE_MODE;
		cfg_data  <= serial;
		@(negedge clk);
		cfg_index <= REG_REPLY_KIND;
		cfg_data  <= pm25;
		@(negedge clk);
		if ($urandom_range(0, 2) == 0) begin
			cfg_index <= $urandom_range(0, 1) ? REG_UNMAPPED_A : REG_UNMAPPED_B;
			cfg_data  <= 1'($urandom);
			@(negedge clk);
		end
		cfg_we <= 1'b0;
		cfg_serial = serial;
		cfg_pm25_only = pm25;
	endtask

	// Prediction on accepted bytes, checking on accepted results, run limit
	always @(posedge clk) begin
		result_t want;
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("%0t: timeout after %0d cycles", $time, cycle_count);
			$display("FAIL sensor_reply_frame_checker");
			$finish;
		end
		byte_taken = arst_n && in_valid && in_ready;
		if (byte_taken) begin
			advance_reply(rx_byte, frame_start);
			accepted_count++;
		end
		if (arst_n && out_valid && out_ready) begin
			if (awaited_replies.size() == 0) begin
				$display("%0t: unexpected result: expected none, actual status %0d pm %0h/%0h/%0h",
					$time, status, pm1p0, pm2p5, pm10);
				mismatch_count++;
			end else begin
				want = awaited_replies.pop_front();
				if (status !== want.status) begin
					$display("%0t: status mismatch: expected %0d, actual %0d",
						$time, want.status, status);
					mismatch_count++;
				end
				if (pm1p0 !== want.pm1p0) begin
					$display("%0t: pm1p0 mismatch: expected %0h, actual %0h",
						$time, want.pm1p0, pm1p0);
					mismatch_count++;
				end
				if (pm2p5 !== want.pm2p5) begin
					$display("%0t: pm2p5 mismatch: expected %0h, actual %0h",
						$time, want.pm2p5, pm2p5);
					mismatch_count++;
				end
				if (pm10 !== want.pm10) begin
					$display("%0t: pm10 mismatch: expected %0h, actual %0h",
						$time, want.pm10, pm10);
					mismatch_count++;
				end
			end
		end
	end

	// Byte sender: random bursts separated by random gaps
	int          burst_left = 0;
	int          gap_left = 0;
	reply_byte_t next_byte;

	always @(negedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || byte_taken) begin
			if (gap_left > 0) begin
				in_valid <= 1'b0;
				gap_left--;
			end else if (pending_bytes.size() != 0) begin
				next_byte = pending_bytes.pop_front();
				in_valid    <= 1'b1;
				rx_byte     <= next_byte.value;
				frame_start <= next_byte.start;
				if (burst_left > 0) begin
					burst_left--;
				end else begin
					burst_left = $urandom_range(1, 48);
					gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
				end
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Result receiver: out_ready follows a randomly chosen stall style, re-picked when its run ends
	int          ready_style = RDY_ALWAYS;
	int          style_left = 0;
	logic [31:0] ready_bits = 32'hFFFF_FFFF;

	always @(negedge clk) begin
		if (style_left == 0) begin
			ready_style = $urandom_range(RDY_ALWAYS, RDY_SPARSE);
			ready_bits = $urandom;
			style_left = $urandom_range(20, 120);
		end else begin
			style_left--;
		end
		case (ready_style)
			RDY_ALWAYS: out_ready <= 1'b1;
			RDY_PATTERN: out_ready <= ready_bits[0];
			default: out_ready <= ready_bits[0] & ready_bits[5];
		endcase
		ready_bits = {ready_bits[0], ready_bits[31:1]};
	end

	// Stimulus sequence
	initial begin
		int       random_base;
		int       reply_total;
		int       full_len;
		int       cut;
		int       pick;
		logic     force_start;
		logic     start_bit;
		logic     serial;
		logic     pm25;
		logic [4:0] faults;

		clear_reply_state();
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: full serial reply with top readings (sum wraps)
		load_settings(1'b1, 1'b0);
		queue_reply(5'b00000, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 30);
		wait_idle();

		// Directed: PM2.5-only, partial reply cut by a new start; command and
		// sum both wrong, so the sum fault must win
		load_settings(1'b1, 1'b1);
		queue_reply(5'b00000, 16'h0000, 16'h1234, 16'h0000, 1'b1, 3);
		queue_reply((5'b1 << FLT_COMMAND) | (5'b1 << FLT_SUM), 16'h0000, 16'h0000,
			16'h0000, 1'b1, 30);
		wait_idle();

		// Random phases, each under its own settings; a phase may end mid-reply
		random_base = queued_count;
		while (queued_count - random_base < RANDOM_BYTES) begin
			serial = 1'($urandom);
			pm25 = 1'($urandom);
			load_settings(serial, pm25);
			full_len = !serial ? 30 : (pm25 ? 7 : 11);
			reply_total = $urandom_range(2, 10);
			force_start = 1'($urandom);
			for (int r = 0; r < reply_total; r++) begin
				pick = $urandom_range(0, 99);
				start_bit = force_start | 1'($urandom);
				force_start = 1'b0;
				if (pick >= 90) begin
					// noise with random frame starts
					repeat ($urandom_range(1, 8))
						queue_byte(8'($urandom), $urandom_range(0, 3) == 0);
					force_start = 1'b1;
				end else begin
					faults = ($urandom_range(0, 2) == 0) ? 5'($urandom & $urandom) : 5'b0;
					cut = full_len;
					if (pick >= 80) begin
						cut = $urandom_range(1, full_len - 1);
						force_start = 1'b1;
					end
					queue_reply(faults, pick_reading(), pick_reading(), pick_reading(),
						start_bit, cut);
				end
			end
			wait_idle();
		end

		repeat (8) @(negedge clk);
		if (mismatch_count == 0 && awaited_replies.size() == 0) begin
			$display("PASS sensor_reply_frame_checker");
		end else begin
			$display("FAIL sensor_reply_frame_checker");
		end
		$finish;
	end

endmodule
